// ===== rtl/core/mlcr_pkg.sv =====
`default_nettype none
package mlcr_pkg;

    localparam logic [22:0] Q        = 23'd8380417;
    localparam logic [22:0] HALF_QM1 = 23'd4190208;

    // gamma2 = (q-1)/32 and (q-1)/88, as signed compare bounds
    localparam logic signed [22:0] G2_WIDE   = 23'sd261888;
    localparam logic signed [22:0] G2_NARROW = 23'sd95232;

    // 2*gamma2
    localparam logic [19:0] TWO_G2_WIDE   = 20'd523776;
    localparam logic [19:0] TWO_G2_NARROW = 20'd190464;

    // reciprocal multipliers for the high part estimate
    localparam logic [13:0] RCP_WIDE   = 14'd1025;
    localparam logic [13:0] RCP_NARROW = 14'd11275;
    localparam logic [5:0]  HI_MAX_NARROW = 6'd43;
    localparam logic [3:0]  HI_MASK_WIDE  = 4'd15;

    // Power2Round rounding, d = 13
    localparam logic [12:0] P2R_BIAS = 13'd4095;

    typedef enum logic [1:0] {
        OP_P2R     = 2'd0,
        OP_DECOMP  = 2'd1,
        OP_MKHINT  = 2'd2,
        OP_USEHINT = 2'd3
    } t_op;

    // side data that rides along with each item through the pipeline
    typedef struct packed {
        logic              gamma;
        t_op               op;
        logic              hint_in;
        logic              hint_out;
        logic [9:0]        p2r_hi;
        logic signed [13:0] p2r_lo;
    } t_tag;

endpackage
`default_nettype wire

// ===== rtl/core/mlcr_decomp.sv =====
`default_nettype none
module mlcr_decomp import mlcr_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [22:0]        i_r,
    input  wire t_tag               i_tag,
    output logic                    o_valid,
    output t_tag                    o_tag,
    output logic [5:0]              o_hi,
    output logic signed [18:0]      o_lo
);

    // stage A: coarse high part and reciprocal product
    logic [22:0] w_r_bias;
    logic [15:0] w_hi0;
    logic [13:0] w_rcp;
    logic        r_a_valid;
    t_tag        r_a_tag;
    logic [22:0] r_a_r;
    logic [29:0] r_a_prod;

    assign w_r_bias = i_r + 23'd127;
    assign w_hi0    = w_r_bias[22:7];
    assign w_rcp    = i_tag.gamma ? RCP_WIDE : RCP_NARROW;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_tag  <= i_tag;
        r_a_r    <= i_r;
        r_a_prod <= {14'd0, w_hi0} * {16'd0, w_rcp};
    end

    // stage B: round the product, wrap at the top
    logic [29:0] w_rnd_w;
    logic [29:0] w_rnd_n;
    logic [5:0]  n_b_hi;
    logic        r_b_valid;
    t_tag        r_b_tag;
    logic [22:0] r_b_r;
    logic [5:0]  r_b_hi;

    assign w_rnd_w = r_a_prod + 30'd2097152;
    assign w_rnd_n = r_a_prod + 30'd8388608;

    always_comb begin
        if (r_a_tag.gamma) begin
            n_b_hi = {2'b00, w_rnd_w[25:22] & HI_MASK_WIDE};
        end else if (w_rnd_n[29:24] > HI_MAX_NARROW) begin
            n_b_hi = 6'd0;
        end else begin
            n_b_hi = w_rnd_n[29:24];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_tag <= r_a_tag;
        r_b_r   <= r_a_r;
        r_b_hi  <= n_b_hi;
    end

    // stage C: hi * 2*gamma2 (fits 23 bits for both settings)
    logic [19:0] w_two_g;
    logic [25:0] w_m;
    logic        r_c_valid;
    t_tag        r_c_tag;
    logic [22:0] r_c_r;
    logic [5:0]  r_c_hi;
    logic [22:0] r_c_m;

    assign w_two_g = r_b_tag.gamma ? TWO_G2_WIDE : TWO_G2_NARROW;
    assign w_m     = {20'd0, r_b_hi} * {6'd0, w_two_g};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
        r_c_tag <= r_b_tag;
        r_c_r   <= r_b_r;
        r_c_hi  <= r_b_hi;
        r_c_m   <= w_m[22:0];
    end

    // stage D: low part, centered mod q
    logic signed [24:0] w_d;
    logic signed [24:0] w_dq;
    logic signed [24:0] n_d_lo;
    logic               r_d_valid;
    t_tag               r_d_tag;
    logic [5:0]         r_d_hi;
    logic signed [18:0] r_d_lo;

    assign w_d  = $signed({2'b00, r_c_r}) - $signed({2'b00, r_c_m});
    assign w_dq = w_d - $signed({2'b00, Q});

    always_comb begin
        if (w_d > $signed({2'b00, HALF_QM1})) begin
            n_d_lo = w_dq;
        end else begin
            n_d_lo = w_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
        r_d_tag <= r_c_tag;
        r_d_hi  <= r_c_hi;
        r_d_lo  <= n_d_lo[18:0];
    end

    assign o_valid = r_d_valid;
    assign o_tag   = r_d_tag;
    assign o_hi    = r_d_hi;
    assign o_lo    = r_d_lo;

endmodule
`default_nettype wire

// ===== rtl/core/mldsa_coefficient_rounding.sv =====
`default_nettype none
// A taken request passes the input register, 4 stages and the output register.
// Throughput: one request per cycle, every cycle; busy never rises.
// The fixed-point decompose chain (reciprocal multiply, round, 2*gamma2 multiply,
// centered subtract) sets the depth. Reset (synchronous, active low) clears the
// valid bits and selects gamma2 = (q-1)/88; the receiver cannot stall results.
module mldsa_coefficient_rounding import mlcr_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [22:0]        i_coeff,
    input  wire logic signed [22:0] i_low_in,
    input  wire logic [5:0]         i_high_in,
    input  wire logic               i_hint_in,
    // result channel
    output logic                    o_strobe,
    output logic [9:0]              o_high_out,
    output logic signed [18:0]      o_low_out,
    output logic                    o_hint_out,
    // configuration: gamma_select
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_data
);

    // Every stage moves every cycle, so requests are always welcome.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    logic w_accept;
    assign w_accept = start && !busy;

    // gamma_select: 1 -> (q-1)/32, 0 -> (q-1)/88
    logic r_gamma;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_gamma <= i_cfg_data;
        end
    end

    // ---------------- stage 1: reduce coefficient, evaluate make hint ----------
    logic [22:0]        w_r;
    logic signed [22:0] w_g;
    logic               w_mk_hint;

    // 2^23 < 2q, so one conditional subtract lands in Z_q
    assign w_r = (i_coeff >= Q) ? (i_coeff - Q) : i_coeff;
    assign w_g = r_gamma ? G2_WIDE : G2_NARROW;

    // hint when |low| exceeds gamma2, or low sits exactly at -gamma2 with a
    // nonzero high part
    assign w_mk_hint = (i_low_in > w_g) || (i_low_in < -w_g)
                     || ((i_low_in == -w_g) && (i_high_in != 6'd0));

    logic        r_s1_valid;
    logic [22:0] r_s1_r;
    t_op         r_s1_op;
    logic        r_s1_gamma;
    logic        r_s1_hint_in;
    logic        r_s1_mk_hint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
        r_s1_r       <= w_r;
        r_s1_op      <= t_op'(i_opcode);
        r_s1_gamma   <= r_gamma;
        r_s1_hint_in <= i_hint_in;
        r_s1_mk_hint <= w_mk_hint;
    end

    // Power2Round is cheap: one add, its results ride in the tag.
    logic [23:0] w_p2r_sum;
    t_tag        w_tag;

    assign w_p2r_sum = {1'b0, r_s1_r} + {11'd0, P2R_BIAS};

    always_comb begin
        w_tag          = '0;
        w_tag.gamma    = r_s1_gamma;
        w_tag.op       = r_s1_op;
        w_tag.hint_in  = r_s1_hint_in;
        w_tag.hint_out = r_s1_mk_hint;
        w_tag.p2r_hi   = w_p2r_sum[22:13];
        // low = r - hi*2^13 = (r + 4095) mod 2^13 - 4095
        w_tag.p2r_lo   = $signed({1'b0, w_p2r_sum[12:0]}) - $signed({1'b0, P2R_BIAS});
    end

    // ---------------- stages 2..5: decompose pipeline ---------------------------
    logic               w_dc_valid;
    t_tag               w_dc_tag;
    logic [5:0]         w_dc_hi;
    logic signed [18:0] w_dc_lo;

    mlcr_decomp u_decomp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_r     (r_s1_r),
        .i_tag   (w_tag),
        .o_valid (w_dc_valid),
        .o_tag   (w_dc_tag),
        .o_hi    (w_dc_hi),
        .o_lo    (w_dc_lo)
    );

    // ---------------- stage 6: use hint, select result, output register -------
    logic [5:0] w_uh_hi;
    logic       w_lo_pos;

    assign w_lo_pos = (w_dc_lo > 19'sd0);

    // step the high part toward the side of the low part, wrapping mod 16 / 44
    always_comb begin
        w_uh_hi = w_dc_hi;
        if (w_dc_tag.hint_in) begin
            if (w_dc_tag.gamma) begin
                w_uh_hi = w_lo_pos ? {2'b00, w_dc_hi[3:0] + 4'd1}
                                   : {2'b00, w_dc_hi[3:0] - 4'd1};
            end else if (w_lo_pos) begin
                w_uh_hi = (w_dc_hi == HI_MAX_NARROW) ? 6'd0 : w_dc_hi + 6'd1;
            end else begin
                w_uh_hi = (w_dc_hi == 6'd0) ? HI_MAX_NARROW : w_dc_hi - 6'd1;
            end
        end
    end

    logic [9:0]         n_high;
    logic signed [18:0] n_low;
    logic               n_hint;

    always_comb begin
        n_high = 10'd0;
        n_low  = 19'sd0;
        n_hint = 1'b0;
        unique case (w_dc_tag.op)
            OP_P2R: begin
                n_high = w_dc_tag.p2r_hi;
                n_low  = 19'(w_dc_tag.p2r_lo);
            end
            OP_DECOMP: begin
                n_high = {4'd0, w_dc_hi};
                n_low  = w_dc_lo;
            end
            OP_MKHINT: begin
                n_hint = w_dc_tag.hint_out;
            end
            OP_USEHINT: begin
                n_high = {4'd0, w_uh_hi};
            end
            default: begin
                n_high = 10'd0;
            end
        endcase
    end

    logic               r_out_valid;
    logic [9:0]         r_out_high;
    logic signed [18:0] r_out_low;
    logic               r_out_hint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_dc_valid;
        end
        r_out_high <= n_high;
        r_out_low  <= n_low;
        r_out_hint <= n_hint;
    end

    assign o_strobe   = r_out_valid;
    assign o_high_out = r_out_high;
    assign o_low_out  = r_out_low;
    assign o_hint_out = r_out_hint;

    // ---------------- checks ----------------------------------------------------
    // every taken request comes out as a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##6 o_strobe)
        else $error("result strobe missing six cycles after a request");

    // nothing strobes that was not requested
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, 6))
        else $error("result strobe without a matching request");

    // narrow setting wraps the high part into 0..43
    a_hi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dc_valid && !w_dc_tag.gamma) |-> (w_dc_hi <= HI_MAX_NARROW))
        else $error("decompose high part beyond 43");

    // a set hint only comes from make hint, which carries no high or low part
    a_hint_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_hint_out) |-> (o_high_out == 10'd0 && o_low_out == 19'sd0))
        else $error("hint result carries a high or low part");

endmodule
`default_nettype wire
